/* sv/scan_disk_request_scheduler_macros.svh */
// Assertion macros used by the checker file of the scheduler.
`ifndef SCAN_DISK_REQUEST_SCHEDULER_MACROS_SVH
`define SCAN_DISK_REQUEST_SCHEDULER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SDRS_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SDRS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/sdrs_pkg.sv */
package sdrs_pkg;

   // The pending map is stored as rows of this many tracks.
   localparam int CHUNK = 32;
   localparam int BIT_W = 5;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_START = 2'd1,
      OP_NEXT  = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ADD_RD,
      S_ADD_WR,
      S_ST_RD0,
      S_ST_WR0,
      S_ST_RD1,
      S_ST_WR1,
      S_DN_RD,
      S_DN_CHK,
      S_UP_RD,
      S_UP_CHK,
      S_RESP
   } state_type;

   typedef enum logic [1:0] {
      RD_CUR,
      RD_TRACK,
      RD_ZERO,
      RD_LAST
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_ADD,
      WR_ZERO,
      WR_LAST
   } wr_sel_type;

   typedef struct packed {
      logic       load;
      logic       start_apply;
      logic       init_row;
      rd_sel_type rd_sel;
      wr_sel_type wr_sel;
      logic       dn_chk;
      logic       up_chk;
   } ctrl_type;

   typedef struct packed {
      logic track_ok;
      logic going_up;
      logic hit;
      logic row_zero;
      logic row_last;
   } status_type;

endpackage

/* sv/sdrs_ctrl.sv */
module sdrs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [1:0]            req_op,
   input  sdrs_pkg::status_type  status,
   output logic                  busy,
   output logic                  rsp_valid,
   output sdrs_pkg::ctrl_type    ctrl
);

   sdrs_pkg::state_type state_ff;
   sdrs_pkg::state_type state_in;
   logic                accept;

   assign accept    = start && (state_ff == sdrs_pkg::S_IDLE);
   assign busy      = (state_ff != sdrs_pkg::S_IDLE);
   assign rsp_valid = (state_ff == sdrs_pkg::S_RESP);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sdrs_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sdrs_pkg::S_IDLE: begin
            if (start) begin
               case (req_op)
                  sdrs_pkg::OP_ADD: begin
                     state_in = status.track_ok ? sdrs_pkg::S_ADD_RD : sdrs_pkg::S_RESP;
                  end
                  sdrs_pkg::OP_START: begin
                     state_in = sdrs_pkg::S_ST_RD0;
                  end
                  sdrs_pkg::OP_NEXT: begin
                     state_in = status.going_up ? sdrs_pkg::S_UP_RD : sdrs_pkg::S_DN_RD;
                  end
                  default: begin
                     state_in = sdrs_pkg::S_RESP;
                  end
               endcase
            end
         end
         sdrs_pkg::S_ADD_RD: state_in = sdrs_pkg::S_ADD_WR;
         sdrs_pkg::S_ADD_WR: state_in = sdrs_pkg::S_RESP;
         sdrs_pkg::S_ST_RD0: state_in = sdrs_pkg::S_ST_WR0;
         sdrs_pkg::S_ST_WR0: state_in = sdrs_pkg::S_ST_RD1;
         sdrs_pkg::S_ST_RD1: state_in = sdrs_pkg::S_ST_WR1;
         sdrs_pkg::S_ST_WR1: state_in = sdrs_pkg::S_RESP;
         sdrs_pkg::S_DN_RD:  state_in = sdrs_pkg::S_DN_CHK;
         sdrs_pkg::S_DN_CHK: begin
            // With no hit in row zero the down pass is over and the up pass starts.
            if (status.hit) begin
               state_in = sdrs_pkg::S_RESP;
            end else if (status.row_zero) begin
               state_in = sdrs_pkg::S_UP_RD;
            end else begin
               state_in = sdrs_pkg::S_DN_RD;
            end
         end
         sdrs_pkg::S_UP_RD:  state_in = sdrs_pkg::S_UP_CHK;
         sdrs_pkg::S_UP_CHK: begin
            if (status.hit || status.row_last) begin
               state_in = sdrs_pkg::S_RESP;
            end else begin
               state_in = sdrs_pkg::S_UP_RD;
            end
         end
         sdrs_pkg::S_RESP:   state_in = sdrs_pkg::S_IDLE;
         default:            state_in = sdrs_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      ctrl             = '0;
      ctrl.rd_sel      = sdrs_pkg::RD_CUR;
      ctrl.wr_sel      = sdrs_pkg::WR_NONE;
      case (state_ff)
         sdrs_pkg::S_IDLE: begin
            ctrl.load        = accept;
            ctrl.start_apply = accept && (req_op == sdrs_pkg::OP_START);
            ctrl.init_row    = accept && (req_op == sdrs_pkg::OP_NEXT);
         end
         sdrs_pkg::S_ADD_RD: ctrl.rd_sel = sdrs_pkg::RD_TRACK;
         sdrs_pkg::S_ADD_WR: ctrl.wr_sel = sdrs_pkg::WR_ADD;
         sdrs_pkg::S_ST_RD0: ctrl.rd_sel = sdrs_pkg::RD_ZERO;
         sdrs_pkg::S_ST_WR0: ctrl.wr_sel = sdrs_pkg::WR_ZERO;
         sdrs_pkg::S_ST_RD1: ctrl.rd_sel = sdrs_pkg::RD_LAST;
         sdrs_pkg::S_ST_WR1: ctrl.wr_sel = sdrs_pkg::WR_LAST;
         sdrs_pkg::S_DN_CHK: ctrl.dn_chk = 1'b1;
         sdrs_pkg::S_UP_CHK: ctrl.up_chk = 1'b1;
         default: begin
         end
      endcase
   end

endmodule

/* sv/sdrs_datapath.sv */
module sdrs_datapath #(
   parameter int TRACKS = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sdrs_pkg::ctrl_type    ctrl,
   input  logic [7:0]            req_track,
   input  logic [7:0]            req_head,
   output sdrs_pkg::status_type  status,
   output logic                  rsp_found,
   output logic [7:0]            rsp_served_track,
   output logic [8:0]            rsp_seek_wait,
   output logic                  rsp_done_res,
   output logic [8:0]            rsp_total_seeks,
   output logic [15:0]           rsp_request_count
);

   localparam int ROWS  = (TRACKS + sdrs_pkg::CHUNK - 1) / sdrs_pkg::CHUNK;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int PW    = ROW_W + sdrs_pkg::BIT_W;

   localparam logic [PW-1:0]    LAST_POS     = PW'(TRACKS - 1);
   localparam logic [ROW_W-1:0] LAST_ROW     = LAST_POS[PW-1:sdrs_pkg::BIT_W];
   localparam logic [ROW_W-1:0] ROW_LAST_IDX = ROW_W'(ROWS - 1);
   localparam logic [sdrs_pkg::BIT_W-1:0] TOP_BIT = sdrs_pkg::BIT_W'(sdrs_pkg::CHUNK - 1);
   localparam logic [sdrs_pkg::CHUNK-1:0] ONES    = '1;
   localparam logic [sdrs_pkg::CHUNK-1:0] ONE     = sdrs_pkg::CHUNK'(1);

   // Row memory of the pending map; a row never written reads as empty.
   logic [sdrs_pkg::CHUNK-1:0] mem [ROWS];
   logic [sdrs_pkg::CHUNK-1:0] rd_data_ff;
   logic                       rd_valid_ff;
   logic [ROWS-1:0]            row_valid_ff;

   logic [7:0]       trk_ff,        trk_in;
   logic [7:0]       start_head_ff, start_head_in;
   logic [PW-1:0]    sweep_ff,      sweep_in;
   logic             going_up_ff,   going_up_in;
   logic [15:0]      count_ff,      count_in;
   logic [ROW_W-1:0] cur_row_ff,    cur_row_in;
   logic             found_ff,      found_in;
   logic [7:0]       served_ff,     served_in;
   logic [8:0]       wait_ff,       wait_in;
   logic             done_ff,       done_in;
   logic [8:0]       total_ff,      total_in;

   logic [PW-1:0]                track_pos;
   logic [ROW_W-1:0]             track_row;
   logic [sdrs_pkg::BIT_W-1:0]   track_bit;
   logic [ROW_W-1:0]             sweep_row;
   logic [sdrs_pkg::BIT_W-1:0]   sweep_bit;
   logic [sdrs_pkg::CHUNK-1:0]   row_word;
   logic                         first_row;
   logic [sdrs_pkg::CHUNK-1:0]   dn_mask;
   logic [sdrs_pkg::CHUNK-1:0]   up_mask;
   logic [sdrs_pkg::CHUNK-1:0]   cand;
   logic                         hit;
   logic [sdrs_pkg::BIT_W-1:0]   hi_bit;
   logic [sdrs_pkg::BIT_W-1:0]   lo_bit;
   logic [sdrs_pkg::BIT_W-1:0]   hit_bit;
   logic [PW-1:0]                hit_pos;
   logic [ROW_W-1:0]             rd_addr;
   logic                         wr_en;
   logic [ROW_W-1:0]             wr_addr;
   logic [sdrs_pkg::CHUNK-1:0]   wr_data;

   assign track_pos = PW'(trk_ff);
   assign track_row = track_pos[PW-1:sdrs_pkg::BIT_W];
   assign track_bit = track_pos[sdrs_pkg::BIT_W-1:0];
   assign sweep_row = sweep_ff[PW-1:sdrs_pkg::BIT_W];
   assign sweep_bit = sweep_ff[sdrs_pkg::BIT_W-1:0];
   assign row_word  = rd_valid_ff ? rd_data_ff : '0;

   // Only the row holding the sweep position is limited by the bit position.
   assign first_row = (cur_row_ff == sweep_row);
   assign dn_mask   = first_row ? (ONES >> (TOP_BIT - sweep_bit)) : ONES;
   assign up_mask   = first_row ? ((ONES << sweep_bit) << 1) : ONES;
   assign cand      = row_word & (ctrl.up_chk ? up_mask : dn_mask);
   assign hit       = |cand;

   always_comb begin
      hi_bit = '0;
      lo_bit = '0;
      for (int i = 0; i < sdrs_pkg::CHUNK; i++) begin
         if (cand[i]) begin
            hi_bit = sdrs_pkg::BIT_W'(i);
         end
      end
      for (int i = sdrs_pkg::CHUNK - 1; i >= 0; i--) begin
         if (cand[i]) begin
            lo_bit = sdrs_pkg::BIT_W'(i);
         end
      end
   end

   assign hit_bit = ctrl.up_chk ? lo_bit : hi_bit;
   assign hit_pos = {cur_row_ff, hit_bit};

   always_comb begin
      case (ctrl.rd_sel)
         sdrs_pkg::RD_TRACK: rd_addr = track_row;
         sdrs_pkg::RD_ZERO:  rd_addr = '0;
         sdrs_pkg::RD_LAST:  rd_addr = LAST_ROW;
         default:            rd_addr = cur_row_ff;
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cur_row_ff;
      wr_data = row_word;
      case (ctrl.wr_sel)
         sdrs_pkg::WR_ADD: begin
            wr_en   = 1'b1;
            wr_addr = track_row;
            wr_data = row_word | (ONE << track_bit);
         end
         sdrs_pkg::WR_ZERO: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = row_word | ONE;
         end
         sdrs_pkg::WR_LAST: begin
            wr_en   = 1'b1;
            wr_addr = LAST_ROW;
            wr_data = row_word | (ONE << LAST_POS[sdrs_pkg::BIT_W-1:0]);
         end
         default: begin
            if ((ctrl.dn_chk || ctrl.up_chk) && hit) begin
               wr_en   = 1'b1;
               wr_data = row_word & ~(ONE << hit_bit);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      trk_in        = trk_ff;
      start_head_in = start_head_ff;
      sweep_in      = sweep_ff;
      going_up_in   = going_up_ff;
      count_in      = count_ff;
      cur_row_in    = cur_row_ff;
      found_in      = found_ff;
      served_in     = served_ff;
      wait_in       = wait_ff;
      done_in       = done_ff;
      total_in      = total_ff;

      if (ctrl.load) begin
         trk_in    = req_track;
         found_in  = 1'b0;
         served_in = '0;
         wait_in   = '0;
         done_in   = 1'b0;
         total_in  = '0;
      end
      if (ctrl.start_apply) begin
         start_head_in = req_head;
         sweep_in      = (int'(req_head) < TRACKS) ? PW'(req_head) : LAST_POS;
         going_up_in   = 1'b0;
      end
      if (ctrl.init_row) begin
         cur_row_in = sweep_row;
      end
      if ((ctrl.wr_sel == sdrs_pkg::WR_ADD) && (count_ff != '1)) begin
         count_in = count_ff + 16'd1;
      end
      if (ctrl.dn_chk) begin
         if (hit) begin
            found_in  = 1'b1;
            served_in = 8'(hit_pos);
            wait_in   = 9'(start_head_ff) - 9'(hit_pos);
            if (hit_pos == '0) begin
               going_up_in = 1'b1;
               sweep_in    = '0;
            end else begin
               sweep_in = hit_pos - PW'(1);
            end
         end else if (cur_row_ff == '0) begin
            going_up_in = 1'b1;
            sweep_in    = '0;
         end else begin
            cur_row_in = cur_row_ff - ROW_W'(1);
         end
      end
      if (ctrl.up_chk) begin
         if (hit) begin
            found_in  = 1'b1;
            served_in = 8'(hit_pos);
            wait_in   = 9'(start_head_ff) + 9'(hit_pos);
            sweep_in  = hit_pos;
         end else if (cur_row_ff == ROW_LAST_IDX) begin
            done_in  = 1'b1;
            total_in = 9'(start_head_ff) + 9'(TRACKS);
         end else begin
            cur_row_in = cur_row_ff + ROW_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff  <= '0;
         rd_valid_ff   <= 1'b0;
         start_head_ff <= '0;
         sweep_ff      <= '0;
         going_up_ff   <= 1'b0;
         count_ff      <= '0;
         cur_row_ff    <= '0;
      end else begin
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff   <= row_valid_ff[rd_addr];
         start_head_ff <= start_head_in;
         sweep_ff      <= sweep_in;
         going_up_ff   <= going_up_in;
         count_ff      <= count_in;
         cur_row_ff    <= cur_row_in;
      end
   end

   always_ff @(posedge clock) begin
      trk_ff    <= trk_in;
      found_ff  <= found_in;
      served_ff <= served_in;
      wait_ff   <= wait_in;
      done_ff   <= done_in;
      total_ff  <= total_in;
   end

   assign status.track_ok = (int'(req_track) < TRACKS);
   assign status.going_up = going_up_ff;
   assign status.hit      = hit;
   assign status.row_zero = (cur_row_ff == '0);
   assign status.row_last = (cur_row_ff == ROW_LAST_IDX);

   assign rsp_found         = found_ff;
   assign rsp_served_track  = served_ff;
   assign rsp_seek_wait     = wait_ff;
   assign rsp_done_res      = done_ff;
   assign rsp_total_seeks   = total_ff;
   assign rsp_request_count = count_ff;

endmodule

/* sv/scan_disk_request_scheduler.sv */
// SCAN (elevator) disk request scheduler.
// A command is transferred at a rising edge where start is high and busy is low.
// req_op selects add (mark req_track pending), start (take req_head as the head
// position and mark the first and last track) or next (serve one pending track).
// Every command gives exactly one result: rsp_valid is high for one cycle and the
// rsp_ ports carry the served track and its seek wait, or done with the total seek
// count; rsp_request_count always shows the saturating count of in-range adds.
// The receiver cannot stall: the result is transferred in the cycle it is shown.
// Timing: busy stays high from the accepting edge until after the result cycle.
// An add reads and then writes the row of its track, a start reads and writes row
// zero and then the last row, and an unknown op or an ignored add goes straight
// to the result. A next does one memory read and one check for every 32-track row
// of the pending map that it visits. The longest next is one given before any start:
// it checks row zero on the way down and then every row on the way up. Commands are
// handled one at a time. Reset (synchronous, active high) clears the pending map
// through per-row valid bits, along with the head, sweep position, direction and count.
module scan_disk_request_scheduler #(
   parameter int TRACKS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_track,
   input  logic [7:0]  req_head,
   output logic        rsp_valid,
   output logic        rsp_found,
   output logic [7:0]  rsp_served_track,
   output logic [8:0]  rsp_seek_wait,
   output logic        rsp_done_res,
   output logic [8:0]  rsp_total_seeks,
   output logic [15:0] rsp_request_count
);

   sdrs_pkg::ctrl_type   ctrl;
   sdrs_pkg::status_type status;

   sdrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_op    (req_op),
      .status    (status),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .ctrl      (ctrl)
   );

   sdrs_datapath #(
      .TRACKS (TRACKS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .req_track         (req_track),
      .req_head          (req_head),
      .status            (status),
      .rsp_found         (rsp_found),
      .rsp_served_track  (rsp_served_track),
      .rsp_seek_wait     (rsp_seek_wait),
      .rsp_done_res      (rsp_done_res),
      .rsp_total_seeks   (rsp_total_seeks),
      .rsp_request_count (rsp_request_count)
   );

endmodule

/* sv/sdrs_checker.sv */
`include "scan_disk_request_scheduler_macros.svh"

module sdrs_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic       rsp_found,
   input logic [7:0] rsp_served_track,
   input logic [8:0] rsp_seek_wait,
   input logic       rsp_done_res,
   input logic [8:0] rsp_total_seeks
);

   // A transferred command keeps the block busy until its result is out.
   `SDRS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "command taken but not busy")
   // A result is shown for one cycle and the block is free right after it.
   `SDRS_ASSERT_NEXT(a_single_result, rsp_valid, !rsp_valid && !busy, "result held too long")
   `SDRS_ASSERT_IMPL(a_found_done, rsp_valid, !(rsp_found && rsp_done_res),
                     "served and done in one result")
   `SDRS_ASSERT_IMPL(a_empty_serve, rsp_valid && !rsp_found,
                     (rsp_served_track == 8'd0) && (rsp_seek_wait == 9'd0),
                     "track or wait given without a served request")
   `SDRS_ASSERT_IMPL(a_total_done, rsp_valid && !rsp_done_res, rsp_total_seeks == 9'd0,
                     "total seeks given before done")

endmodule

bind scan_disk_request_scheduler sdrs_checker u_sdrs_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;

   localparam int NUM_TRACKS = 256;
   localparam int RANDOM_ITEMS = 1200;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic        found;
      logic [7:0]  served;
      logic [8:0]  wait_len;
      logic        done;
      logic [8:0]  total;
      logic [15:0] count;
   } sched_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [1:0]  req_op = 2'd0;
   logic [7:0]  req_track = 8'd0;
   logic [7:0]  req_head = 8'd0;
   logic        busy;
   logic        rsp_valid;
   logic        rsp_found;
   logic [7:0]  rsp_served_track;
   logic [8:0]  rsp_seek_wait;
   logic        rsp_done_res;
   logic [8:0]  rsp_total_seeks;
   logic [15:0] rsp_request_count;

   // Predicted scheduler state.
   logic          trk_pending [0:NUM_TRACKS-1];
   logic [7:0]    head_pos;
   logic [7:0]    sweep_at;
   logic          upward;
   logic [15:0]   add_total;

   sched_result_type expected_results [$];
   sched_result_type last_pred;
   logic          idle_on = 1'b0;
   int            items_sent = 0;
   int            results_checked = 0;
   int            tracks_served = 0;
   int            sweeps_done = 0;
   int            fail_count = 0;

   scan_disk_request_scheduler #(.TRACKS(NUM_TRACKS)) u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_track(req_track),
      .req_head(req_head),
      .rsp_valid(rsp_valid),
      .rsp_found(rsp_found),
      .rsp_served_track(rsp_served_track),
      .rsp_seek_wait(rsp_seek_wait),
      .rsp_done_res(rsp_done_res),
      .rsp_total_seeks(rsp_total_seeks),
      .rsp_request_count(rsp_request_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #50_000_000;
      $display("scan_disk_request_scheduler regression: fail");
      $finish;
   end

   // Works out the result of one command and advances the predicted state.
   function automatic sched_result_type scan_predict(input logic [1:0] op,
                                                     input logic [7:0] trk,
                                                     input logic [7:0] hd);
      sched_result_type r;
      int i;
      r = '0;
      case (op)
         sdrs_pkg::OP_ADD: begin
            trk_pending[trk] = 1'b1;
            if (add_total != 16'hFFFF) add_total = add_total + 16'd1;
         end
         sdrs_pkg::OP_START: begin
            head_pos = hd;
            sweep_at = hd;
            upward = 1'b0;
            trk_pending[0] = 1'b1;
            trk_pending[NUM_TRACKS-1] = 1'b1;
         end
         sdrs_pkg::OP_NEXT: begin
            if (!upward) begin
               for (i = int'(sweep_at); i >= 0; i--) begin
                  if (trk_pending[i]) begin
                     trk_pending[i] = 1'b0;
                     r.found = 1'b1;
                     r.served = 8'(i);
                     r.wait_len = 9'(int'(head_pos) - i);
                     if (i == 0) begin
                        upward = 1'b1;
                        sweep_at = 8'd0;
                     end else begin
                        sweep_at = 8'(i - 1);
                     end
                     break;
                  end
               end
               if (!r.found) begin
                  upward = 1'b1;
                  sweep_at = 8'd0;
               end
            end
            if (!r.found && upward) begin
               for (i = int'(sweep_at) + 1; i < NUM_TRACKS; i++) begin
                  if (trk_pending[i]) begin
                     trk_pending[i] = 1'b0;
                     r.found = 1'b1;
                     r.served = 8'(i);
                     r.wait_len = 9'(int'(head_pos) + i);
                     sweep_at = 8'(i);
                     break;
                  end
               end
               if (!r.found) begin
                  r.done = 1'b1;
                  r.total = 9'(int'(head_pos) + NUM_TRACKS);
               end
            end
         end
         default: ;
      endcase
      r.count = add_total;
      return r;
   endfunction

   task automatic idle_gap(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // Offers one command and waits for its transfer.
   task automatic send_cmd(input logic [1:0] op, input logic [7:0] trk,
                           input logic [7:0] hd);
      if (idle_on && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 9));
      @(negedge clock);
      start <= 1'b1;
      req_op <= op;
      req_track <= trk;
      req_head <= hd;
      do @(posedge clock); while (busy);
      last_pred = scan_predict(op, trk, hd);
      expected_results.push_back(last_pred);
      items_sent++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // Serves requests, mixing in up to extra_adds adds, until the sweep reports done or the guard runs out.
   task automatic run_sweep(input int extra_adds);
      int guard;
      guard = 0;
      do begin
         if (extra_adds > 0 && $urandom_range(0, 7) == 0) begin
            send_cmd(sdrs_pkg::OP_ADD, 8'($urandom), 8'($urandom));
            extra_adds--;
         end
         send_cmd(sdrs_pkg::OP_NEXT, 8'($urandom), 8'($urandom));
         guard++;
      end while (!last_pred.done && guard < 600);
   endtask

   always @(posedge clock) begin
      sched_result_type want;
      sched_result_type got;
      if (!reset && rsp_valid) begin
         got = {rsp_found, rsp_served_track, rsp_seek_wait, rsp_done_res,
                rsp_total_seeks, rsp_request_count};
         if (expected_results.size() == 0) begin
            if (fail_count < 10)
               $display("%0t: result with nothing expected: found=%0d track=%0d",
                        $realtime, got.found, got.served);
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            results_checked++;
            if (want.found) tracks_served++;
            if (want.done) sweeps_done++;
            if (got !== want) begin
               if (fail_count < 10) begin
                  $display("%0t: mismatch (expected/actual) found %0d/%0d track %0d/%0d",
                           $realtime, want.found, got.found, want.served, got.served);
                  $display("   wait %0d/%0d done %0d/%0d total %0d/%0d count %0d/%0d",
                           want.wait_len, got.wait_len, want.done, got.done,
                           want.total, got.total, want.count, got.count);
               end
               fail_count++;
            end
         end
      end
   end

   task automatic test_next_before_start();
      send_cmd(sdrs_pkg::OP_NEXT, 8'd0, 8'd0);
      send_cmd(sdrs_pkg::OP_ADD, 8'd7, 8'd0);
      send_cmd(sdrs_pkg::OP_NEXT, 8'd0, 8'd0);
      send_cmd(sdrs_pkg::OP_NEXT, 8'd0, 8'd0);
   endtask

   task automatic test_directed_extremes();
      send_cmd(sdrs_pkg::OP_ADD, 8'd0, 8'd0);
      send_cmd(sdrs_pkg::OP_ADD, 8'd255, 8'd0);
      send_cmd(sdrs_pkg::OP_ADD, 8'd255, 8'd255);
      send_cmd(sdrs_pkg::OP_ADD, 8'd128, 8'd0);
      send_cmd(OP_UNUSED, 8'd255, 8'd255);
      send_cmd(sdrs_pkg::OP_START, 8'd0, 8'd255);
      run_sweep(0);
      send_cmd(sdrs_pkg::OP_NEXT, 8'd0, 8'd0);
      send_cmd(sdrs_pkg::OP_START, 8'd255, 8'd0);
      send_cmd(sdrs_pkg::OP_ADD, 8'd1, 8'd0);
      run_sweep(0);
      send_cmd(sdrs_pkg::OP_ADD, 8'd210, 8'd0);
      send_cmd(sdrs_pkg::OP_ADD, 8'd150, 8'd0);
      send_cmd(sdrs_pkg::OP_START, 8'd0, 8'd200);
      send_cmd(sdrs_pkg::OP_NEXT, 8'd0, 8'd0);
      send_cmd(sdrs_pkg::OP_START, 8'd0, 8'd100);
      run_sweep(0);
   endtask

   // Mostly complete sweeps with random content, some cut short, some noise.
   task automatic test_random_sweeps(input int item_goal, input bit allow_idle);
      int stop_at;
      int seq_idx;
      int kind;
      int n;
      logic [7:0] hd;
      stop_at = items_sent + item_goal;
      seq_idx = 0;
      while (items_sent < stop_at) begin
         idle_on = allow_idle && ($urandom_range(0, 2) != 0);
         kind = $urandom_range(0, 9);
         if (kind <= 6) begin
            hd = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 8'd255 : 8'd0)
                                             : 8'($urandom);
            n = $urandom_range(0, 10);
            repeat (n) send_cmd(sdrs_pkg::OP_ADD, 8'($urandom), 8'($urandom));
            send_cmd(sdrs_pkg::OP_START, 8'($urandom), hd);
            run_sweep($urandom_range(0, 3));
            repeat ($urandom_range(0, 2))
               send_cmd(sdrs_pkg::OP_NEXT, 8'($urandom), 8'($urandom));
         end else if (kind == 7) begin
            send_cmd(sdrs_pkg::OP_START, 8'($urandom), 8'($urandom));
            repeat ($urandom_range(1, 4))
               send_cmd(sdrs_pkg::OP_NEXT, 8'($urandom), 8'($urandom));
         end else begin
            repeat ($urandom_range(1, 6))
               send_cmd(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
         end
         seq_idx++;
         if (seq_idx % 50 == 0) drain_results();
      end
   endtask

   // Marks every track, then sweeps the full map.
   task automatic test_full_map();
      int t;
      idle_on = 1'b0;
      for (t = 0; t < NUM_TRACKS; t++) send_cmd(sdrs_pkg::OP_ADD, 8'(t), 8'($urandom));
      send_cmd(sdrs_pkg::OP_START, 8'd0, 8'($urandom));
      run_sweep(4);
      drain_results();
   endtask

   initial begin
      for (int i = 0; i < NUM_TRACKS; i++) trk_pending[i] = 1'b0;
      head_pos = 8'd0;
      sweep_at = 8'd0;
      upward = 1'b0;
      add_total = 16'd0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      test_next_before_start();
      test_directed_extremes();
      test_random_sweeps(RANDOM_ITEMS, 1'b1);
      drain_results();
      test_full_map();
      idle_on = 1'b0;
      test_random_sweeps(150, 1'b0);

      drain_results();
      repeat (64) @(posedge clock);
      $display("Ran %0d commands, checked %0d results: %0d tracks served, %0d done reports,",
               items_sent, results_checked, tracks_served, sweeps_done);
      $display("including next before start, duplicate adds and a sweep over a full map.");
      if (fail_count == 0) begin
         $display("scan_disk_request_scheduler regression: pass");
      end else begin
         $display("%0d failures", fail_count);
         $display("scan_disk_request_scheduler regression: fail");
      end
      $finish;
   end

endmodule
